/* rtl/aes128_pkg.sv */
// Package with AES-128 types, S-box functions and column mixing helpers.
`default_nettype none
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int KeyEntries = 11;

    typedef logic [127:0] block_t;
    typedef logic [3:0] round_t;

    typedef enum logic [2:0] {
        ST_KEY_LOAD,
        ST_KEY_EXPAND,
        ST_DEC_KEYS,
        ST_IDLE,
        ST_ADD_KEY,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam logic [0:0] AddrKeyHigh = 1'b0;
    localparam logic [0:0] AddrKeyLow  = 1'b1;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ x;
            end
            x = xtime(x);
        end
        gmul = p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Byte i of the block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s, input logic inv);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] =
                        INV_SBOX[get_byte(s, r + 4 * c)];
                end
                else
                begin
                    t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
                end
            end
        end
        sub_shift = t;
    endfunction

    function automatic block_t mix(input block_t s, input logic inv);
        block_t t;
        logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
        t = '0;
        m0 = inv ? 8'd14 : 8'd2;
        m1 = inv ? 8'd11 : 8'd3;
        m2 = inv ? 8'd13 : 8'd1;
        m3 = inv ? 8'd9 : 8'd1;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 8]  = gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3);
            t[119 - 32 * c -: 8]  = gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2);
            t[111 - 32 * c -: 8]  = gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1);
            t[103 - 32 * c -: 8]  = gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0);
        end
        mix = t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

/* rtl/aes128_block_cipher.sv */
// AES-128 encrypt/decrypt engine with round key memories and an APB key port.
// Each block passes through the key addition, ten rounds and the result load, in that order.
// A new block is accepted only after the previous result is loaded; one shared round unit.
// Key schedule: after reset or a key write, the key load and expansion states build the
// encryption keys, then decryption keys are derived; no block is accepted in these states.
// Reset: rst_n is asynchronous, active low, clears the key registers to zero.
`default_nettype none
module aes128_block_cipher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low
);
    import aes128_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    state_t      state_reg, state_next;
    round_t      cnt_reg, cnt_next;
    block_t      prev_key_reg;
    logic [7:0]  rcon_reg;
    block_t      state_blk_reg;
    logic        dec_reg;
    logic        out_valid_reg;
    block_t      out_reg;

    block_t      enc_mem [KeyEntries];
    block_t      dec_mem [KeyEntries];
    block_t      enc_rd_reg, dec_rd_reg;
    round_t      rd_addr;

    logic        cfg_wr;
    logic        in_acc;
    logic        out_acc;
    logic        out_load;
    block_t      exp_key;
    logic [31:0] tw;
    block_t      rk;
    block_t      ss;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == AddrKeyLow) ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            if (paddr[3] == AddrKeyHigh)
            begin
                key_high_reg <= pwdata;
            end
            else
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_acc);

    always_comb
    begin
        tw = sub_word({prev_key_reg[23:0], prev_key_reg[31:24]}) ^ {rcon_reg, 24'h0};
        exp_key[127:96] = prev_key_reg[127:96] ^ tw;
        exp_key[95:64]  = prev_key_reg[95:64] ^ exp_key[127:96];
        exp_key[63:32]  = prev_key_reg[63:32] ^ exp_key[95:64];
        exp_key[31:0]   = prev_key_reg[31:0] ^ exp_key[63:32];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_KEY_LOAD:
            begin
                state_next = ST_KEY_EXPAND;
                cnt_next   = 4'd1;
            end
            ST_KEY_EXPAND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NumRounds))
                begin
                    state_next = ST_DEC_KEYS;
                    cnt_next   = 4'd0;
                end
            end
            ST_DEC_KEYS:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NumRounds + 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = 4'd0;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_ADD_KEY;
                    cnt_next   = 4'd0;
                end
            end
            ST_ADD_KEY:
            begin
                state_next = ST_ROUND;
                cnt_next   = 4'd1;
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NumRounds))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_KEY_LOAD;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = ST_KEY_LOAD;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_DEC_KEYS:
            begin
                rd_addr = (cnt_reg > 4'(NumRounds)) ? 4'd0 : 4'(NumRounds) - cnt_reg;
            end
            ST_IDLE:
            begin
                rd_addr = 4'd0;
            end
            ST_ADD_KEY, ST_ROUND:
            begin
                rd_addr = (cnt_reg == 4'(NumRounds)) ? 4'd0 : cnt_reg + 4'd1;
            end
            default:
            begin
                rd_addr = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        enc_rd_reg <= enc_mem[rd_addr];
        dec_rd_reg <= dec_mem[rd_addr];
        if (state_reg == ST_KEY_LOAD)
        begin
            enc_mem[0] <= {key_high_reg, key_low_reg};
        end
        else if (state_reg == ST_KEY_EXPAND)
        begin
            enc_mem[cnt_reg] <= exp_key;
        end
        if (state_reg == ST_DEC_KEYS && cnt_reg != 4'd0)
        begin
            if (cnt_reg == 4'd1 || cnt_reg == 4'(NumRounds + 1))
            begin
                dec_mem[cnt_reg - 4'd1] <= enc_rd_reg;
            end
            else
            begin
                dec_mem[cnt_reg - 4'd1] <= mix(enc_rd_reg, 1'b1);
            end
        end
    end

    assign rk = dec_reg ? dec_rd_reg : enc_rd_reg;
    assign ss = sub_shift(state_blk_reg, dec_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KEY_LOAD)
        begin
            prev_key_reg <= {key_high_reg, key_low_reg};
            rcon_reg     <= 8'h01;
        end
        else if (state_reg == ST_KEY_EXPAND)
        begin
            prev_key_reg <= exp_key;
            rcon_reg     <= xtime(rcon_reg);
        end
        if (in_acc)
        begin
            state_blk_reg <= {block_high, block_low};
            dec_reg       <= req_type;
        end
        else if (state_reg == ST_ADD_KEY)
        begin
            state_blk_reg <= state_blk_reg ^ rk;
        end
        else if (state_reg == ST_ROUND)
        begin
            if (cnt_reg == 4'(NumRounds))
            begin
                state_blk_reg <= ss ^ rk;
            end
            else
            begin
                state_blk_reg <= mix(ss, dec_reg) ^ rk;
            end
        end
        if (out_load)
        begin
            out_reg <= state_blk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KEY_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = out_reg[127:64];
    assign result_low  = out_reg[63:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_ADD_KEY)
    else $error("Accepted beat did not start the key addition.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid_reg)
    else $error("Finished block was not presented.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_reg))
    else $error("Stalled result changed.");

endmodule
`default_nettype wire

/* tb/aes128_block_cipher_tb.sv */
// Self-checking testbench for the AES-128 encrypt/decrypt engine with APB key writes.
`default_nettype none
module aes128_block_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aes128_pkg::*;

    localparam logic [3:0] RegKeyHigh = 4'd0;
    localparam logic [3:0] RegKeyLow  = 4'd8;
    localparam logic       ReqEncrypt = 1'b0;
    localparam logic       ReqDecrypt = 1'b1;
    localparam int         CycleLimit = 400000;

    class cipher_scoreboard;
        block_t expected_blocks[$];
        int     mismatches;
        int     checked;

        function void note_block(block_t b);
            expected_blocks.push_back(b);
        endfunction

        function void check_block(logic [63:0] hi, logic [63:0] lo);
            block_t want;
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", hi, lo);
                return;
            end
            want = expected_blocks.pop_front();
            checked++;
            if (want[127:64] !== hi || want[63:0] !== lo)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h %h, got %h %h",
                             want[127:64], want[63:0], hi, lo);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [63:0] block_high = '0, block_low = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_high, result_low;

    cipher_scoreboard board = new();
    logic [63:0] key_high_q = '0, key_low_q = '0;
    block_t      enc_keys[11];
    block_t      dec_keys[11];
    int          cycles = 0;
    int          encrypts = 0, decrypts = 0, key_writes = 0;

    aes128_block_cipher dut (.*);

    always #5 clk = ~clk;

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] gf_inv(logic [7:0] a);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 254; i++)
            r = gf_mul(r, a);
        return r;
    endfunction

    function automatic logic [7:0] rol8(logic [7:0] b, int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic logic [7:0] fwd_sub(logic [7:0] a);
        logic [7:0] b;
        b = gf_inv(a);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] rev_sub(logic [7:0] a);
        return gf_inv(rol8(a, 1) ^ rol8(a, 3) ^ rol8(a, 6) ^ 8'h05);
    endfunction

    logic [7:0] fwd_tab[256], rev_tab[256];

    function automatic logic [7:0] byte_of(block_t s, int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t substitute_rows(block_t s, logic inv);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inv)
                    t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = rev_tab[byte_of(s, r + 4 * c)];
                else
                    t[127 - 8 * (r + 4 * c) -: 8] = fwd_tab[byte_of(s, r + 4 * ((c + r) & 3))];
        return t;
    endfunction

    function automatic block_t mix_columns(block_t s, logic inv);
        block_t t;
        logic [7:0] a[4];
        logic [7:0] m[4];
        if (inv)
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
                a[j] = byte_of(s, 4 * c + j);
            for (int row = 0; row < 4; row++)
                t[127 - 8 * (4 * c + row) -: 8] =
                    gf_mul(a[0], m[(4 - row) & 3]) ^ gf_mul(a[1], m[(5 - row) & 3]) ^
                    gf_mul(a[2], m[(6 - row) & 3]) ^ gf_mul(a[3], m[(7 - row) & 3]);
        end
        return t;
    endfunction

    function automatic void expand_key();
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        w[0] = key_high_q[63:32];
        w[1] = key_high_q[31:0];
        w[2] = key_low_q[63:32];
        w[3] = key_low_q[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i - 1];
            if ((i & 3) == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            enc_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        for (int r = 0; r < 11; r++)
            dec_keys[r] = (r == 0 || r == 10) ? enc_keys[10 - r]
                                               : mix_columns(enc_keys[10 - r], 1'b1);
    endfunction

    function automatic block_t cipher_block(logic dec, block_t s);
        s ^= dec ? dec_keys[0] : enc_keys[0];
        for (int r = 1; r <= 10; r++)
        begin
            s = substitute_rows(s, dec);
            if (r != 10)
                s = mix_columns(s, dec);
            s ^= dec ? dec_keys[r] : enc_keys[r];
        end
        return s;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("aes128_block_cipher_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_block(result_high, result_low);
    end

    initial
    begin
        int g;
        forever
        begin
            @(posedge clk);
            g = $urandom_range(0, 99);
            out_stall <= (g < 25) ? 1'b1 : (g < 27 ? 1'b1 : 1'b0);
            if (g < 2)
            begin
                repeat ($urandom_range(10, 40)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drain();
        while (board.expected_blocks.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(logic [3:0] addr, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == RegKeyHigh)
            key_high_q = value;
        else
            key_low_q = value;
        key_writes++;
        expand_key();
    endtask

    task automatic send_block(logic dec, logic [63:0] hi, logic [63:0] lo);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        in_valid <= 1'b1;
        req_type <= dec;
        block_high <= hi;
        block_low <= lo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_block(cipher_block(dec, {hi, lo}));
        if (dec)
            decrypts++;
        else
            encrypts++;
        in_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_blocks(int n);
        logic [63:0] hi, lo;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0: begin hi = '1; lo = '1; end
                1: begin hi = '0; lo = rand64(); end
                default: begin hi = rand64(); lo = rand64(); end
            endcase
            send_block(1'($urandom_range(0, 1)), hi, lo);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            fwd_tab[i] = fwd_sub(i[7:0]);
            rev_tab[i] = rev_sub(i[7:0]);
        end
        expand_key();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key first, then the standard test key, then the extremes.
        send_block(ReqEncrypt, 64'h0, 64'h0);
        send_block(ReqDecrypt, 64'h0, 64'h0);
        send_block(ReqEncrypt, '1, '1);
        send_block(ReqDecrypt, '1, '1);
        wait_drain();
        write_key(RegKeyHigh, 64'h0001020304050607);
        write_key(RegKeyLow, 64'h08090a0b0c0d0e0f);
        send_block(ReqEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(ReqDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(ReqEncrypt, 64'h8000000000000000, 64'h0000000000000001);
        send_block(ReqDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_drain();
        write_key(RegKeyHigh, '1);
        write_key(RegKeyLow, '1);
        send_block(ReqEncrypt, '1, 64'h0);
        send_block(ReqDecrypt, 64'h0, '1);
        wait_drain();
        write_key(RegKeyLow, 64'h0);
        send_block(ReqEncrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(ReqDecrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drain();
            write_key(RegKeyHigh, rand64());
            if (phase != 3)
                write_key(RegKeyLow, rand64());
            random_blocks(140);
        end
        wait_drain();

        $display("covered %0d encrypt and %0d decrypt blocks under %0d key writes",
                 encrypts, decrypts, key_writes);
        $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.expected_blocks.size() == 0)
            $display("aes128_block_cipher_tb: done, clean");
        else
            $display("aes128_block_cipher_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
